>>> sv/mbe_pkg.sv
// shared types, constants and helpers for the escape-time pixel evaluator
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    localparam int FX_BITS       = 32;
    localparam int PROD_BITS     = 64;
    localparam int WIDE_BITS     = 66;
    localparam int MUL_OP_BITS   = 33;
    localparam int REG_BITS      = 31;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 2;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 24;
    localparam int DEF_ITER_BITS  = 16;
    localparam int DEF_ITER_LIMIT = 32;
    // default window: 4.0 wide over this many pixel steps
    localparam int WIN_PIXELS     = 479;
    localparam int DEF_HALF_WIDTH = 2;
    localparam int DEF_ESCAPE     = 4;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_ZOOM  = 2'd0,
        CFG_STEP  = 2'd1,
        CFG_ESC   = 2'd2,
        CFG_LIMIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MCX,
        S_MCY,
        S_CY,
        S_SQX,
        S_SQY,
        S_TEST,
        S_UPD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_STEP_COL,
        MUL_STEP_ROW,
        MUL_XX,
        MUL_YY,
        MUL_XY
    } mul_sel_t;

    typedef struct packed {
        logic     en;
        mul_sel_t sel;
    } mul_ctl_t;

    // clamp a wide signed value to the signed fixed-point word
    function automatic logic signed [FX_BITS-1:0] sat_fx(input logic signed [WIDE_BITS-1:0] v);
        logic signed [FX_BITS-1:0] r;
        begin
            if (!v[WIDE_BITS-1] && (|v[WIDE_BITS-2:FX_BITS-1]))
            begin
                r = {1'b0, {(FX_BITS-1){1'b1}}};
            end
            else if (v[WIDE_BITS-1] && !(&v[WIDE_BITS-2:FX_BITS-1]))
            begin
                r = {1'b1, {(FX_BITS-1){1'b0}}};
            end
            else
            begin
                r = v[FX_BITS-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/mbe_in_if.sv
// pixel coordinate input channel
`timescale 1ns / 1ps
`default_nettype none

interface mbe_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

`default_nettype wire

>>> sv/mbe_out_if.sv
// pixel result output channel
`timescale 1ns / 1ps
`default_nettype none

interface mbe_out_if #(
    parameter int COORD_BITS = 12,
    parameter int ITER_BITS  = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;
    logic                  escaped;
    logic [ITER_BITS-2:0]  colour;

    modport source (output valid, output out_col, output out_row, output escaped,
                    output colour, input ready);
    modport sink   (input valid, input out_col, input out_row, input escaped,
                    input colour, output ready);
endinterface

`default_nettype wire

>>> sv/mbe_cfg_if.sv
// register write channel
`timescale 1ns / 1ps
`default_nettype none

interface mbe_cfg_if #(
    parameter int ADDR_BITS = 2,
    parameter int DATA_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mbe_cfg_regs.sv
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none

module mbe_cfg_regs
    import mbe_pkg::*;
#(
    parameter int                  ITER_BITS = DEF_ITER_BITS,
    parameter logic [REG_BITS-1:0] ZOOM_RST  = '0,
    parameter logic [REG_BITS-1:0] STEP_RST  = '0,
    parameter logic [REG_BITS-1:0] ESC_RST   = '0,
    parameter logic [ITER_BITS-1:0] LIMIT_RST = '0
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mbe_cfg_if.sink                   cfg,
    output logic [REG_BITS-1:0]       zoom,
    output logic [REG_BITS-1:0]       step,
    output logic [REG_BITS-1:0]       esc,
    output logic [ITER_BITS-1:0]      limit
);

    logic [REG_BITS-1:0]  zoom_reg;
    logic [REG_BITS-1:0]  step_reg;
    logic [REG_BITS-1:0]  esc_reg;
    logic [ITER_BITS-1:0] limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg  <= ZOOM_RST;
            step_reg  <= STEP_RST;
            esc_reg   <= ESC_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.addr))
                CFG_ZOOM:  zoom_reg  <= cfg.data[REG_BITS-1:0];
                CFG_STEP:  step_reg  <= cfg.data[REG_BITS-1:0];
                CFG_ESC:   esc_reg   <= cfg.data[REG_BITS-1:0];
                CFG_LIMIT: limit_reg <= cfg.data[ITER_BITS-1:0];
                default:   ;
            endcase
        end
    end

    assign zoom  = zoom_reg;
    assign step  = step_reg;
    assign esc   = esc_reg;
    assign limit = limit_reg;

endmodule

`default_nettype wire

>>> sv/mbe_mul.sv
// shared signed multiplier with operand select and registered product
`timescale 1ns / 1ps
`default_nettype none

module mbe_mul
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  wire logic                          clk,
    input  wire mul_ctl_t                      ctl,
    input  wire logic [REG_BITS-1:0]           step,
    input  wire logic [COORD_BITS-1:0]         col,
    input  wire logic [COORD_BITS-1:0]         row,
    input  wire logic signed [FX_BITS-1:0]     x,
    input  wire logic signed [FX_BITS-1:0]     y,
    output logic signed [PROD_BITS-1:0]        prod
);

    logic signed [MUL_OP_BITS-1:0]   op_a;
    logic signed [MUL_OP_BITS-1:0]   op_b;
    logic signed [2*MUL_OP_BITS-1:0] full;
    logic signed [PROD_BITS-1:0]     prod_reg;

    always_comb
    begin
        op_a = {{(MUL_OP_BITS-REG_BITS){1'b0}}, step};
        op_b = {{(MUL_OP_BITS-COORD_BITS){1'b0}}, col};
        case (ctl.sel)
            MUL_STEP_COL:
            begin
                op_a = {{(MUL_OP_BITS-REG_BITS){1'b0}}, step};
                op_b = {{(MUL_OP_BITS-COORD_BITS){1'b0}}, col};
            end
            MUL_STEP_ROW:
            begin
                op_a = {{(MUL_OP_BITS-REG_BITS){1'b0}}, step};
                op_b = {{(MUL_OP_BITS-COORD_BITS){1'b0}}, row};
            end
            MUL_XX:
            begin
                op_a = {x[FX_BITS-1], x};
                op_b = {x[FX_BITS-1], x};
            end
            MUL_YY:
            begin
                op_a = {y[FX_BITS-1], y};
                op_b = {y[FX_BITS-1], y};
            end
            MUL_XY:
            begin
                op_a = {x[FX_BITS-1], x};
                op_b = {y[FX_BITS-1], y};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign full = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= full[PROD_BITS-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> sv/mbe_core.sv
// iteration sequencer, fixed-point datapath and result register
`timescale 1ns / 1ps
`default_nettype none

module mbe_core
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ITER_BITS  = DEF_ITER_BITS
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    mbe_in_if.sink                         pix_in,
    mbe_out_if.source                      pix_out,
    input  wire logic [REG_BITS-1:0]       zoom,
    input  wire logic [REG_BITS-1:0]       esc,
    input  wire logic [ITER_BITS-1:0]      limit,
    input  wire logic signed [PROD_BITS-1:0] prod,
    output mul_ctl_t                       mul_ctl,
    output logic [COORD_BITS-1:0]          col,
    output logic [COORD_BITS-1:0]          row,
    output logic signed [FX_BITS-1:0]      x,
    output logic signed [FX_BITS-1:0]      y
);

    localparam int MAG_BITS = PROD_BITS - FRAC_BITS;

    state_t state_reg;
    state_t state_next;

    logic [COORD_BITS-1:0]         col_reg;
    logic [COORD_BITS-1:0]         row_reg;
    logic signed [FX_BITS-1:0]     cx_reg;
    logic signed [FX_BITS-1:0]     cy_reg;
    logic signed [FX_BITS-1:0]     x_reg;
    logic signed [FX_BITS-1:0]     y_reg;
    logic signed [PROD_BITS-1:0]   xx_reg;
    logic signed [PROD_BITS-1:0]   diff_reg;
    logic [ITER_BITS-1:0]          iter_reg;
    logic                          esc_flag_reg;

    logic                          out_valid_reg;
    logic [COORD_BITS-1:0]         out_col_reg;
    logic [COORD_BITS-1:0]         out_row_reg;
    logic                          escaped_reg;
    logic [ITER_BITS-2:0]          colour_reg;

    logic                          in_ready;
    logic                          done_load;

    logic signed [WIDE_BITS-1:0]   cx_wide;
    logic signed [WIDE_BITS-1:0]   cy_wide;
    logic [PROD_BITS-1:0]          mag_sum;
    logic [MAG_BITS-1:0]           mag;
    logic [MAG_BITS-1:0]           esc_ext;
    logic                          keep_going;
    logic signed [PROD_BITS-1:0]   diff_w;
    logic signed [PROD_BITS-1:0]   diff_sh;
    logic signed [PROD_BITS-1:0]   xy_sh;
    logic signed [WIDE_BITS-1:0]   nx_wide;
    logic signed [WIDE_BITS-1:0]   ny_wide;

    // c from pixel coordinates, product is never negative here
    assign cx_wide = {{(WIDE_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod}
                   - {{(WIDE_BITS-REG_BITS){1'b0}}, zoom};
    assign cy_wide = {{(WIDE_BITS-REG_BITS){1'b0}}, zoom}
                   - {{(WIDE_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};

    // squared magnitude, both squares non-negative so the sum fits unsigned
    assign mag_sum    = xx_reg + prod;
    assign mag        = mag_sum[PROD_BITS-1:FRAC_BITS];
    assign esc_ext    = MAG_BITS'(esc);
    assign keep_going = (iter_reg < limit) && (mag < esc_ext);
    assign diff_w     = xx_reg - prod;

    // floor shifts back to the fixed-point scale, then add c
    assign diff_sh = diff_reg >>> FRAC_BITS;
    assign xy_sh   = prod >>> (FRAC_BITS - 1);
    assign nx_wide = {{(WIDE_BITS-PROD_BITS){diff_sh[PROD_BITS-1]}}, diff_sh}
                   + {{(WIDE_BITS-FX_BITS){cx_reg[FX_BITS-1]}}, cx_reg};
    assign ny_wide = {{(WIDE_BITS-PROD_BITS){xy_sh[PROD_BITS-1]}}, xy_sh}
                   + {{(WIDE_BITS-FX_BITS){cy_reg[FX_BITS-1]}}, cy_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pix_in.valid)
                begin
                    state_next = S_MCX;
                end
            end
            S_MCX:  state_next = S_MCY;
            S_MCY:  state_next = S_CY;
            S_CY:   state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_TEST;
            S_TEST: state_next = keep_going ? S_UPD : S_DONE;
            S_UPD:  state_next = S_SQX;
            S_DONE:
            begin
                if (done_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        done_load   = 1'b0;
        mul_ctl.en  = 1'b0;
        mul_ctl.sel = MUL_XX;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_MCX:
            begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = MUL_STEP_COL;
            end
            S_MCY:
            begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = MUL_STEP_ROW;
            end
            S_SQX:
            begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = MUL_XX;
            end
            S_SQY:
            begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = MUL_YY;
            end
            S_TEST:
            begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = MUL_XY;
            end
            S_DONE: done_load = !out_valid_reg || pix_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                col_reg <= pix_in.col;
                row_reg <= pix_in.row;
            end
            S_MCY:  cx_reg <= sat_fx(cx_wide);
            S_CY:
            begin
                cy_reg   <= sat_fx(cy_wide);
                x_reg    <= '0;
                y_reg    <= '0;
                iter_reg <= '0;
            end
            S_SQY:  xx_reg <= prod;
            S_TEST:
            begin
                diff_reg     <= diff_w;
                esc_flag_reg <= mag > esc_ext;
            end
            S_UPD:
            begin
                x_reg    <= sat_fx(nx_wide);
                y_reg    <= sat_fx(ny_wide);
                iter_reg <= iter_reg + 1'b1;
            end
            default: ;
        endcase
        if (done_load)
        begin
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            escaped_reg <= esc_flag_reg;
            colour_reg  <= iter_reg[ITER_BITS-1:1];
        end
    end

    assign pix_in.ready    = in_ready;
    assign pix_out.valid   = out_valid_reg;
    assign pix_out.out_col = out_col_reg;
    assign pix_out.out_row = out_row_reg;
    assign pix_out.escaped = escaped_reg;
    assign pix_out.colour  = colour_reg;

    assign col = col_reg;
    assign row = row_reg;
    assign x   = x_reg;
    assign y   = y_reg;

    // an update only runs after the count test passed
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> iter_reg < limit)
        else $error("iteration count past limit in update");

    // a finished result waits while the output word is still held
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !pix_out.ready) |=> state_reg == S_DONE)
        else $error("result overwrote a pending output word");

    // an accepted pixel starts the coordinate products
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> state_reg == S_MCX)
        else $error("accepted pixel did not start");

    // the output word is only loaded from the done state
    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("output word loaded outside done state");

endmodule

`default_nettype wire

>>> sv/mandelbrot_escape_time_top.sv
// escape-time pixel evaluator, top level
// usage:
//   pix_in  : one word per pixel (col, row); ready only while the evaluator is idle
//   pix_out : one word per pixel (out_col, out_row, escaped, colour)
//   cfg     : register writes (addr 0 half width, 1 pixel step, 2 escape value,
//             3 iteration limit); always ready, write only while idle
// c = (step*col - zoom, zoom - step*row) in signed fixed point with FRAC_BITS
// fraction bits; z = z*z + c is iterated from zero until the count reaches the
// limit or |z|^2 is no longer below the escape value
// all products go through one shared 33x33 multiplier, at most one product per
// cycle: step*col and step*row to form c, then per iteration x*x, y*y and x*y
// with the escape test, followed by the z update; the last pass ends at the test
// and the result is then loaded into the output register
// pix_in ready returns in the cycle after the result is loaded
// the result sits in an output register, so a new pixel is accepted while a
// stalled result still waits; a second result waits in the done state until
// the receiver takes the first
// reset clears the sequencer and output valid and loads the default registers
// (half width 2.0, step 4/479, escape 4.0, limit 32)
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_top
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ITER_BITS  = DEF_ITER_BITS
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mbe_in_if.sink      pix_in,
    mbe_out_if.source   pix_out,
    mbe_cfg_if.sink     cfg
);

    // register reset values scale with the fraction width
    localparam logic [REG_BITS-1:0] ZOOM_RST =
        REG_BITS'(64'(DEF_HALF_WIDTH) << FRAC_BITS);
    localparam logic [REG_BITS-1:0] STEP_RST =
        REG_BITS'((64'(2 * DEF_HALF_WIDTH) << FRAC_BITS) / WIN_PIXELS);
    localparam logic [REG_BITS-1:0] ESC_RST =
        REG_BITS'(64'(DEF_ESCAPE) << FRAC_BITS);
    localparam logic [ITER_BITS-1:0] LIMIT_RST = ITER_BITS'(DEF_ITER_LIMIT);

    logic [REG_BITS-1:0]          zoom;
    logic [REG_BITS-1:0]          step;
    logic [REG_BITS-1:0]          esc;
    logic [ITER_BITS-1:0]         limit;
    mul_ctl_t                     mul_ctl;
    logic signed [PROD_BITS-1:0]  prod;
    logic [COORD_BITS-1:0]        col;
    logic [COORD_BITS-1:0]        row;
    logic signed [FX_BITS-1:0]    x;
    logic signed [FX_BITS-1:0]    y;

    // configuration registers
    mbe_cfg_regs #(
        .ITER_BITS (ITER_BITS),
        .ZOOM_RST  (ZOOM_RST),
        .STEP_RST  (STEP_RST),
        .ESC_RST   (ESC_RST),
        .LIMIT_RST (LIMIT_RST)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .zoom  (zoom),
        .step  (step),
        .esc   (esc),
        .limit (limit)
    );

    // shared multiplier, product valid the cycle after it is issued
    mbe_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk  (clk),
        .ctl  (mul_ctl),
        .step (step),
        .col  (col),
        .row  (row),
        .x    (x),
        .y    (y),
        .prod (prod)
    );

    // sequencer, z update, escape test and output register
    mbe_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .zoom    (zoom),
        .esc     (esc),
        .limit   (limit),
        .prod    (prod),
        .mul_ctl (mul_ctl),
        .col     (col),
        .row     (row),
        .x       (x),
        .y       (y)
    );

endmodule

`default_nettype wire
